FILE: rtl/core/bpa_pkg.sv
`default_nettype none
package bpa_pkg;
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ARG   = 2'd1;
    localparam logic [1:0] ST_OOM   = 2'd2;
    localparam logic [1:0] ST_NOTIN = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] address;
        logic [32:0] size_bytes;
        logic [32:0] alignment;
    } bpa_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] result_address;
    } bpa_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/bpa_req_if.sv
`default_nettype none
interface bpa_req_if
    import bpa_pkg::*;
();
    logic     valid;
    logic     ready;
    bpa_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bpa_rsp_if.sv
`default_nettype none
interface bpa_rsp_if
    import bpa_pkg::*;
();
    logic     valid;
    logic     ready;
    bpa_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bitmap_page_allocator.sv
// Channel   Dir  Payload
// req       in   command, address, size_bytes, alignment
// rsp       out  status, result_address
// cfg       in   cfg_we, cfg_index (0 node_base, 1 node_pages), cfg_data
// The bitmap is a memory of 64-bit words with a registered read port that
// follows the page pointer. After rst_n a clearing pass writes one word per
// cycle and req stays low meanwhile. Init rewrites every word, one per
// cycle, after the setup state. Allocate checks one page per cycle, but
// waits whenever the pointer enters another word until that word is read;
// marking and free read each word touched, then write it back. req is not
// ready while a request is at work or its response waits; rsp holds until
// taken.
`default_nettype none
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES  = 2048,
    parameter int PAGE_SHIFT = 21
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    bpa_req_if.sink          req,
    bpa_rsp_if.source        rsp,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);
    localparam int NBITS = MAX_PAGES;
    localparam int WORDS = (MAX_PAGES + 63) / 64;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(MAX_PAGES + 1) + 1;
    localparam logic [PW-7:0] LAST_WORD  = (PW-6)'(WORDS - 1);
    localparam logic [PW:0]   WORD_PAGES = {{(PW-6){1'b0}}, 7'd64};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;
    localparam logic [2:0] S_INIT  = 3'd6;

    logic [2:0]       state_reg;
    logic [63:0]      base_cfg_reg;
    logic [11:0]      pages_cfg_reg;
    bpa_req_t         cmd_reg;
    logic [PW-1:0]    np_reg;
    logic [PW-1:0]    p_reg;        // page pointer
    logic [PW-1:0]    stop_reg;     // fill end
    logic [PW-1:0]    cand_reg;
    logic [PW-1:0]    blk_reg;      // page offset within block
    logic [33:0]      n_reg;        // block pages
    logic [33:0]      need_reg;
    logic [34:0]      run_reg;      // pages of the current free run
    logic             fill_val_reg;
    logic [1:0]       st_reg;
    logic [63:0]      addr_reg;
    logic             boot_reg;     // clearing pass after reset
    logic [PW-7:0]    rd_idx_reg;   // word held in rd_word_reg
    logic [63:0]      rd_word_reg;

    // free-page bitmap, 1 = free
    logic [63:0] bm_mem [0:WORDS-1];

    // effective node
    logic [PW-1:0] np_eff;
    logic [63:0]   base_eff;
    always_comb
    begin
        if ({20'd0, pages_cfg_reg} > 32'(MAX_PAGES))
            np_eff = PW'(MAX_PAGES);
        else
            np_eff = PW'(pages_cfg_reg);
        base_eff = base_cfg_reg & ~((64'd1 << PAGE_SHIFT) - 64'd1);
    end

    // allocate argument checks, size in bytes rounded up to the alignment
    logic [32:0] al, sz;
    logic [33:0] size_rnd;
    logic        al_bad;
    logic [63:0] off0;
    assign al = cmd_reg.alignment;
    assign sz = cmd_reg.size_bytes;
    assign al_bad = (al == 33'd0) || ((al & (al - 33'd1)) != 33'd0)
        || (al < 33'(64'd1 << PAGE_SHIFT));
    assign size_rnd = ({1'b0, sz} + {1'b0, al} - 34'd1) & ~({1'b0, al} - 34'd1);
    assign off0 = ((64'd0 - base_eff) & {31'd0, al - 33'd1}) >> PAGE_SHIFT;

    // free range check
    logic [63:0] total, rel, last_b;
    logic [64:0] rel_end;
    assign total   = {{(64-PW){1'b0}}, np_eff} << PAGE_SHIFT;
    assign rel     = cmd_reg.address - base_eff;
    assign rel_end = {1'b0, rel} + {32'd0, sz};
    assign last_b  = 64'(({1'b0, rel} + {32'd0, sz} + (65'd1 << PAGE_SHIFT) - 65'd1)
        >> PAGE_SHIFT);

    // page lookup in the registered word
    logic [PW-7:0] p_word;
    logic [WAW-1:0] mem_addr;
    logic          rd_hit;
    logic          in_node;
    logic          pbit;
    logic          pready;
    assign p_word   = p_reg[PW-1:6];
    assign mem_addr = p_reg[WAW+5:6];
    assign rd_hit   = (rd_idx_reg == p_word);
    assign in_node  = (p_reg < np_reg);
    assign pbit     = in_node && rd_word_reg[p_reg[5:0]];
    assign pready   = !in_node || rd_hit;

    // word-wide fill and init values
    logic [PW:0]  word_end;
    logic         stop_past;
    logic [63:0]  fill_mask, fill_word, init_word, mem_wdata;
    logic         init_last;
    logic         fill_go;
    logic         mem_we;
    assign word_end  = {1'b0, p_word, 6'd0} + WORD_PAGES;
    assign stop_past = ({1'b0, stop_reg} >= word_end);
    assign fill_mask = (64'hFFFF_FFFF_FFFF_FFFF << p_reg[5:0])
        & (stop_past ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << stop_reg[5:0]) - 64'd1));
    assign fill_word = fill_val_reg ? (rd_word_reg | fill_mask) : (rd_word_reg & ~fill_mask);
    assign init_word = ({1'b0, np_reg} >= word_end) ? 64'hFFFF_FFFF_FFFF_FFFF
        : (np_reg > p_reg) ? ((64'd1 << np_reg[5:0]) - 64'd1) : 64'd0;
    assign init_last = (p_word == LAST_WORD);
    assign fill_go   = (state_reg == S_FILL) && (p_reg < stop_reg) && rd_hit;
    assign mem_we    = (state_reg == S_INIT) || (fill_go && (p_reg < PW'(NBITS)));
    assign mem_wdata = (state_reg == S_INIT) ? init_word : fill_word;

    // bitmap memory, read address follows the page pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bm_mem[mem_addr] <= mem_wdata;
        rd_word_reg <= bm_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            base_cfg_reg  <= '0;
            pages_cfg_reg <= '0;
            cmd_reg       <= '0;
            np_reg        <= '0;
            p_reg         <= '0;
            stop_reg      <= '0;
            cand_reg      <= '0;
            blk_reg       <= '0;
            n_reg         <= '0;
            need_reg      <= '0;
            run_reg       <= '0;
            fill_val_reg  <= 1'b0;
            st_reg        <= ST_OK;
            addr_reg      <= '0;
            boot_reg      <= 1'b1;
            rd_idx_reg    <= '0;
        end
        else
        begin
            rd_idx_reg <= p_word;
            if (cfg_we)
            begin
                if (cfg_index)
                    pages_cfg_reg <= cfg_data[11:0];
                else
                    base_cfg_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg   <= req.data;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    np_reg   <= np_eff;
                    addr_reg <= '0;
                    st_reg   <= ST_OK;
                    p_reg    <= '0;
                    case (cmd_reg.command)
                        CMD_INIT:
                        begin
                            state_reg <= S_INIT;
                        end
                        CMD_ALLOC:
                        begin
                            if (al_bad || sz == 33'd0)
                            begin
                                st_reg    <= ST_ARG;
                                state_reg <= S_RESP;
                            end
                            else
                            begin
                                n_reg    <= 34'({1'b0, al} >> PAGE_SHIFT);
                                need_reg <= size_rnd >> PAGE_SHIFT;
                                run_reg  <= '0;
                                blk_reg  <= '0;
                                // offset past node means no block at all
                                if (off0 >= {{(64-PW){1'b0}}, np_eff})
                                begin
                                    st_reg    <= ST_OOM;
                                    state_reg <= S_RESP;
                                end
                                else
                                begin
                                    p_reg     <= off0[PW-1:0];
                                    cand_reg  <= off0[PW-1:0];
                                    state_reg <= S_SCAN;
                                end
                            end
                        end
                        CMD_FREE:
                        begin
                            if (rel > total || rel_end > {1'b0, total})
                            begin
                                st_reg    <= ST_NOTIN;
                                state_reg <= S_RESP;
                            end
                            else if (sz == 33'd0)
                                state_reg <= S_RESP;
                            else
                            begin
                                p_reg        <= PW'(rel >> PAGE_SHIFT);
                                stop_reg     <= (last_b < {{(64-PW){1'b0}}, np_eff})
                                    ? last_b[PW-1:0] : np_eff;
                                fill_val_reg <= 1'b1;
                                state_reg    <= S_FILL;
                            end
                        end
                        default:
                        begin
                            st_reg    <= ST_ARG;
                            state_reg <= S_RESP;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    // one page of the current block per cycle, waiting for its word
                    if (pready)
                    begin
                        if (!pbit)
                        begin
                            // block fails: skip to the next block
                            p_reg    <= PW'({1'b0, cand_reg} + 35'(run_reg) - 35'(run_reg)
                                + 35'(p_reg) - 35'(cand_reg) - 35'(blk_reg) + 35'(n_reg));
                            cand_reg <= PW'(35'(p_reg) - 35'(blk_reg) + 35'(n_reg));
                            run_reg  <= '0;
                            blk_reg  <= '0;
                            if (35'(p_reg) - 35'(blk_reg) + 35'(n_reg) >= 35'(np_reg))
                            begin
                                st_reg    <= ST_OOM;
                                state_reg <= S_RESP;
                            end
                        end
                        else if (35'(blk_reg) + 35'd1 == 35'(n_reg))
                        begin
                            // block complete
                            blk_reg <= '0;
                            run_reg <= run_reg + 35'(n_reg);
                            p_reg   <= p_reg + PW'(1);
                            if (run_reg + 35'(n_reg) >= 35'(need_reg))
                            begin
                                p_reg     <= cand_reg;
                                stop_reg  <= PW'(35'(cand_reg) + 35'(need_reg));
                                addr_reg  <= base_eff + ({{(64-PW){1'b0}}, cand_reg}
                                    << PAGE_SHIFT);
                                fill_val_reg <= 1'b0;
                                state_reg <= S_FILL;
                            end
                            else if (35'(p_reg) + 35'd1 >= 35'(np_reg))
                            begin
                                st_reg    <= ST_OOM;
                                state_reg <= S_RESP;
                            end
                        end
                        else
                        begin
                            blk_reg <= blk_reg + PW'(1);
                            p_reg   <= p_reg + PW'(1);
                        end
                    end
                end
                S_FILL:
                begin
                    // read the word, then write back the covered bits
                    if (p_reg >= stop_reg)
                        state_reg <= S_RESP;
                    else if (rd_hit)
                        p_reg <= stop_past ? word_end[PW-1:0] : stop_reg;
                end
                S_INIT:
                begin
                    // one word per cycle: node pages free, the rest used
                    if (init_last)
                    begin
                        boot_reg  <= 1'b0;
                        state_reg <= boot_reg ? S_IDLE : S_RESP;
                    end
                    else
                        p_reg <= p_reg + PW'(64);
                end
                S_RESP:
                begin
                    if (rsp.ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_RESP);
    assign rsp.data.status = st_reg;
    assign rsp.data.result_address = (st_reg == ST_OK) ? addr_reg : 64'd0;
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
    import bpa_pkg::*;

    localparam int MAX_PG   = 2048;
    localparam int PG_SHIFT = 21;
    localparam logic [63:0] PG_SIZE = 64'd1 << PG_SHIFT;
    localparam int STALL_LIMIT = 20000;
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_PAGES = 1'b1;
    localparam logic [1:0] CMD_BAD = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    bpa_req_if req_ch();
    bpa_rsp_if rsp_ch();

    bitmap_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state: one bit per page, 1 = free
    logic [MAX_PG-1:0] page_free_map;
    logic [63:0]       node_base_q;
    logic [11:0]       node_pages_q;

    bpa_req_t pending_req[$];
    bpa_rsp_t expected_rsp[$];
    int       error_count;
    int       req_count;
    int       idle_cycles;
    int       hold_left;
    bit       hold_done;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] usable_pages();
        return (node_pages_q > MAX_PG) ? 64'(MAX_PG) : 64'(node_pages_q);
    endfunction

    function automatic logic [63:0] aligned_base();
        return node_base_q & ~(PG_SIZE - 64'd1);
    endfunction

    function automatic bit run_is_free(logic [63:0] first, logic [63:0] count,
                                       logic [63:0] np);
        if (first > np || count > np - first)
            return 1'b0;
        for (logic [63:0] p = first; p < first + count; p++)
            if (!page_free_map[p])
                return 1'b0;
        return 1'b1;
    endfunction

    // allocate: first fit over aligned blocks
    function automatic bpa_rsp_t model_alloc(logic [63:0] size, logic [63:0] align);
        bpa_rsp_t    r;
        logic [63:0] np;
        logic [63:0] base;
        logic [63:0] blk;
        logic [63:0] need;
        logic [63:0] off;
        logic [63:0] cand;
        np   = usable_pages();
        base = aligned_base();
        r.status = ST_OOM;
        r.result_address = '0;
        if (align == 0 || (align & (align - 64'd1)) != 0 || align < PG_SIZE || size == 0)
        begin
            r.status = ST_ARG;
            return r;
        end
        size = (size + align - 64'd1) & ~(align - 64'd1);
        blk  = align >> PG_SHIFT;
        need = size >> PG_SHIFT;
        off  = ((64'd0 - base) & (align - 64'd1)) >> PG_SHIFT;
        cand = off;
        while (off < np) begin
            if (!run_is_free(off, blk, np)) begin
                off += blk;
                cand = off;
            end else begin
                off += blk;
                if (off - cand >= need) begin
                    for (logic [63:0] p = cand; p < cand + need; p++)
                        page_free_map[p] = 1'b0;
                    r.status = ST_OK;
                    r.result_address = base + (cand << PG_SHIFT);
                    return r;
                end
            end
        end
        return r;
    endfunction

    // free: release every page touched by the byte range
    function automatic logic [1:0] model_free(logic [63:0] addr, logic [63:0] size);
        logic [63:0] np;
        logic [63:0] total;
        logic [63:0] rel;
        logic [63:0] last;
        np    = usable_pages();
        total = np << PG_SHIFT;
        rel   = addr - aligned_base();
        if (rel > total || size > total - rel)
            return ST_NOTIN;
        if (size == 0)
            return ST_OK;
        last = (rel + size + PG_SIZE - 64'd1) >> PG_SHIFT;
        for (logic [63:0] p = rel >> PG_SHIFT; p < last && p < np; p++)
            page_free_map[p] = 1'b1;
        return ST_OK;
    endfunction

    function automatic bpa_rsp_t predict_response(bpa_req_t r);
        bpa_rsp_t rsp;
        logic [63:0] np;
        rsp.status = ST_ARG;
        rsp.result_address = '0;
        case (r.command)
            CMD_INIT: begin
                np = usable_pages();
                page_free_map = '0;
                for (logic [63:0] p = 0; p < np; p++)
                    page_free_map[p] = 1'b1;
                rsp.status = ST_OK;
            end
            CMD_ALLOC: rsp = model_alloc(64'(r.size_bytes), 64'(r.alignment));
            CMD_FREE:  rsp.status = model_free(r.address, 64'(r.size_bytes));
            default:   rsp.status = ST_ARG;
        endcase
        if (rsp.status != ST_OK)
            rsp.result_address = '0;
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic bit quiet_window();
        return req_count >= 250 && req_count < 320;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n) begin
        bit drive;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            drive = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                expected_rsp.push_back(predict_response(pending_req.pop_front()));
                req_count++;
                drive = 1'b0;
            end
            if (!drive && pending_req.size() != 0 &&
                (quiet_window() || $urandom_range(99) >= 32)) begin
                drive = 1'b1;
                req_ch.data <= pending_req[0];
            end
            req_ch.valid <= drive;
        end
    end

    // response ready, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (!hold_done && req_count >= 120) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= quiet_window() || $urandom_range(99) >= 32;
        end
    end

    // response checker and stall watchdog
    always @(posedge clk) begin
        bpa_rsp_t want;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected response", 64'(rsp_ch.data.status), 64'd0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp_ch.data.status !== want.status)
                        report_mismatch("status", 64'(rsp_ch.data.status),
                                        64'(want.status));
                    if (rsp_ch.data.result_address !== want.result_address)
                        report_mismatch("result_address", rsp_ch.data.result_address,
                                        want.result_address);
                end
            end
            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic bpa_req_t make_req(logic [1:0] cmd, logic [63:0] addr,
                                          logic [32:0] size, logic [32:0] align);
        bpa_req_t r;
        r.command    = cmd;
        r.address    = addr;
        r.size_bytes = size;
        r.alignment  = align;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [32:0] rand_align();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            return 33'd1 << (PG_SHIFT + $urandom_range(0, 3));
        else if (pick < 85)
            return 33'd1 << (PG_SHIFT + $urandom_range(4, 11));
        else if (pick < 90)
            return 33'd1 << $urandom_range(0, PG_SHIFT - 1);
        else if (pick < 93)
            return 33'd0;
        return {1'($urandom()), $urandom()};
    endfunction

    function automatic logic [32:0] rand_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return 33'($urandom_range(1, 6)) * 33'(PG_SIZE) - 33'($urandom_range(0, 1 << 20));
        else if (pick < 90)
            return 33'd0;
        else if (pick < 93)
            return 33'd1 << 32;
        return {1'($urandom()), $urandom()};
    endfunction

    // random request shaped around the current node
    function automatic bpa_req_t rand_req(logic [63:0] base, int pages);
        int pick;
        logic [63:0] addr;
        pick = $urandom_range(99);
        addr = (base & ~(PG_SIZE - 64'd1)) +
               (64'($urandom_range(0, (pages > 0) ? pages : 1)) << PG_SHIFT) +
               64'($urandom_range(0, 32'(PG_SIZE) - 1));
        if ($urandom_range(9) == 0)
            addr = rand64();
        if (pick < 50)
            return make_req(CMD_ALLOC, rand64(), rand_size(), rand_align());
        else if (pick < 88)
            return make_req(CMD_FREE, addr, rand_size(), rand_align());
        else if (pick < 95)
            return make_req(CMD_INIT, rand64(), rand_size(), rand_align());
        return make_req(CMD_BAD, rand64(), rand_size(), rand_align());
    endfunction

    task automatic wait_idle();
        while (pending_req.size() != 0 || expected_rsp.size() != 0 || req_ch.valid)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_BASE)
            node_base_q = value;
        else
            node_pages_q = value[11:0];
    endtask

    // stimulus: directed checks, then phases of random requests
    initial begin
        logic [63:0] bases[8];
        int          sizes[8];
        int          counts[8];
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_BASE;
        cfg_data     = '0;
        rst_n        = 1'b0;
        page_free_map = '0;
        node_base_q  = '0;
        node_pages_q = '0;
        error_count  = 0;
        req_count    = 0;
        idle_cycles  = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // offline node right after reset
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'(PG_SIZE), 33'(PG_SIZE)));
        pending_req.push_back(make_req(CMD_FREE, '0, 33'd0, 33'd0));
        wait_idle();
        write_reg(CFG_BASE, 64'd0);
        write_reg(CFG_PAGES, 64'd64);
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'(PG_SIZE), 33'(PG_SIZE)));
        pending_req.push_back(make_req(CMD_INIT, '0, '0, '0));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'(PG_SIZE), 33'd0));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'(PG_SIZE), 33'd3 << 20));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'(PG_SIZE), 33'd1 << 20));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'd0, 33'(PG_SIZE)));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'd1, 33'd1 << 32));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'd1 << 32, 33'(PG_SIZE)));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'd1, 33'(PG_SIZE)));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'd3 << 20, 33'd4 << 20));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'd40 << 21, 33'(PG_SIZE)));
        pending_req.push_back(make_req(CMD_FREE, 64'hFFFF_FFFF_FFFF_FFFF, 33'd1, '0));
        pending_req.push_back(make_req(CMD_FREE, 64'd5 << 21, 33'd0, '0));
        pending_req.push_back(make_req(CMD_FREE, (64'd2 << 21) + 64'd7, 33'd5, '0));
        pending_req.push_back(make_req(CMD_FREE, (64'd30 << 21) + 64'd7, 33'd40 << 20, '0));
        pending_req.push_back(make_req(CMD_FREE, 64'd63 << 21, 33'd3 << 20, '0));
        pending_req.push_back(make_req(CMD_FREE, 64'd64 << 21, 33'd0, '0));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'd20 << 21, 33'd4 << 21));
        pending_req.push_back(make_req(CMD_FREE, 64'd0, 33'd64 << 21, '0));
        pending_req.push_back(make_req(CMD_ALLOC, '0, 33'd64 << 21, 33'(PG_SIZE)));
        pending_req.push_back(make_req(CMD_BAD, '1, '1, '1));

        // node settings: small nodes carry most of the load
        bases  = '{64'd0, 64'hFFFF_FFFF_FFE0_0000, 64'h0000_0123_4567_89AB, 64'd0,
                   64'h8000_0000_0012_3456, 64'h0000_0000_0060_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h0000_0040_0000_0000};
        sizes  = '{64, 40, 100, 0, 4095, 2048, 1, 150};
        counts = '{140, 70, 80, 20, 8, 8, 20, 80};
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            write_reg(CFG_BASE, bases[ph]);
            write_reg(CFG_PAGES, 64'(sizes[ph]));
            pending_req.push_back(make_req(CMD_INIT, rand64(), '0, '0));
            for (int i = 0; i < counts[ph]; i++) begin
                if (sizes[ph] > 1000 && i % 3 == 0)
                    pending_req.push_back(make_req(CMD_ALLOC, '0,
                        33'($urandom_range(1, 2500)) << PG_SHIFT, 33'd1 << 32));
                else
                    pending_req.push_back(rand_req(bases[ph], sizes[ph]));
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_req_if.sv
rtl/core/bpa_rsp_if.sv
rtl/core/bitmap_page_allocator.sv
bench/tb_top.sv
